### sv/serial_loaded_led_pattern_player_top_assert.svh
// assertion macros for the serial loaded led pattern player
// used by the top level; expects clk_i and rst_ni in scope
`ifndef SERIAL_LOADED_LED_PATTERN_PLAYER_TOP_ASSERT_SVH
`define SERIAL_LOADED_LED_PATTERN_PLAYER_TOP_ASSERT_SVH

// same-cycle implication
`define SLP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("slp check failed");

// next-cycle implication
`define SLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("slp check failed");

`endif

### sv/slp_pkg.sv
// shared types and constants of the serial loaded led pattern player
// no dependencies
package slp_pkg;

  localparam int unsigned MAX_STEPS_DEF = 16;

  localparam int unsigned LED_W    = 4;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned LIMIT_W  = 15;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CIDX_W   = 2;
  localparam int unsigned TICK_W   = 32;

  localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = 16'd500;
  localparam logic [CFG_W-1:0]    TICKS_RST      = 16'd40;
  localparam logic [LIMIT_W-1:0]  PMAX_RST       = 15'd2000;
  localparam logic [LIMIT_W-1:0]  PMIN_RST       = 15'd50;
  localparam logic [BYTE_W-1:0]   ASCII_ZERO     = 8'd48;

  typedef enum logic [1:0] {
    MODE_BYTE   = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_SLOWER = 2'd2,
    MODE_FASTER = 2'd3
  } mode_e;

  typedef enum logic [CIDX_W-1:0] {
    REG_TICKS_PER_MS = 2'd0,
    REG_PERIOD_MAX   = 2'd1,
    REG_PERIOD_MIN   = 2'd2
  } cfg_reg_e;

  // per item info handed from the state update to the output stage
  typedef struct packed {
    logic                fire;
    logic                ack;
    logic                playing;
    logic [PERIOD_W-1:0] period;
  } slp_item_t;

endpackage

### sv/slp_ifs.sv
// valid/ready channels of the serial loaded led pattern player
// depends on slp_pkg
interface slp_item_if;
  import slp_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, mode, rx_byte, input ready);
  modport sink   (input valid, mode, rx_byte, output ready);
endinterface

interface slp_res_if;
  import slp_pkg::*;
  logic                valid;
  logic                ready;
  logic [LED_W-1:0]    leds;
  logic                ack_valid;
  logic                playing;
  logic [PERIOD_W-1:0] period_now;
  modport source (output valid, leds, ack_valid, playing, period_now, input ready);
  modport sink   (input valid, leds, ack_valid, playing, period_now, output ready);
endinterface

interface slp_cfg_if;
  import slp_pkg::*;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CFG_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/slp_ram.sv
// generic single write port ram with registered read
// no dependencies
module slp_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/slp_ctrl.sv
// state update of the player: config registers, load and play indexes,
// tick counter, period and the pattern memory ports; depends on slp_pkg and slp_ifs
module slp_ctrl #(
  parameter int unsigned MAX_STEPS = slp_pkg::MAX_STEPS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  slp_cfg_if.sink                                       cfg_i,
  input  logic                                          acc_i,
  input  logic [1:0]                                    mode_i,
  input  logic [slp_pkg::BYTE_W-1:0]                    rx_byte_i,
  output logic                                          we_o,
  output logic [(MAX_STEPS > 1 ? $clog2(MAX_STEPS) : 1)-1:0] waddr_o,
  output logic [slp_pkg::LED_W-1:0]                     wdata_o,
  output logic                                          re_o,
  output logic [(MAX_STEPS > 1 ? $clog2(MAX_STEPS) : 1)-1:0] raddr_o,
  output logic                                          rd_valid_o,
  output slp_pkg::slp_item_t                            item_o
);
  import slp_pkg::*;

  localparam int unsigned IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_STEPS + 1);
  localparam logic [TICK_W-1:0] PROD_RST = TICK_W'(DEFAULT_PERIOD * TICKS_RST);

  logic [CFG_W-1:0]    ticks_q, ticks_d;
  logic [LIMIT_W-1:0]  pmax_q, pmax_d;
  logic [LIMIT_W-1:0]  pmin_q, pmin_d;
  logic [CNT_W-1:0]    step_q, step_d;
  logic [CNT_W-1:0]    load_q, load_d;
  logic [IDX_W-1:0]    play_q, play_d;
  logic                running_q, running_d;
  logic [TICK_W-1:0]   count_q, count_d;
  logic [PERIOD_W-1:0] period_q, period_d;
  logic [TICK_W-1:0]   prod_q;
  logic [MAX_STEPS-1:0] vld_q;
  logic                rd_valid_q;
  logic                fire, ack;

  assign cfg_i.ready = 1'b1;

  // config writes; indexes beyond the list are dropped
  always_comb begin
    ticks_d = ticks_q;
    pmax_d  = pmax_q;
    pmin_d  = pmin_q;
    if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_TICKS_PER_MS: ticks_d = cfg_i.data;
        REG_PERIOD_MAX:   pmax_d  = cfg_i.data[LIMIT_W-1:0];
        REG_PERIOD_MIN:   pmin_d  = cfg_i.data[LIMIT_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    logic [BYTE_W:0]     len;
    logic [CNT_W-1:0]    play_inc;
    logic [PERIOD_W:0]   dbl;
    logic [PERIOD_W-1:0] half;
    logic                due;

    len      = {1'b0, rx_byte_i} - {1'b0, ASCII_ZERO};
    play_inc = CNT_W'(play_q) + CNT_W'(1);
    dbl      = {period_q, 1'b0};
    half     = period_q >> 1;
    // counter reached period*ticks-1, or the product is zero
    due      = (prod_q == '0) || (({1'b0, count_q} + 33'd1) >= {1'b0, prod_q});

    step_d    = step_q;
    load_d    = load_q;
    play_d    = play_q;
    running_d = running_q;
    count_d   = count_q;
    period_d  = period_q;
    we_o      = 1'b0;
    waddr_o   = IDX_W'(load_q - CNT_W'(1));
    wdata_o   = rx_byte_i[LED_W-1:0];
    fire      = 1'b0;
    ack       = 1'b0;

    if (acc_i) begin
      case (mode_e'(mode_i))
        MODE_BYTE: begin
          if (load_q == '0) begin
            running_d = 1'b0;
            load_d    = CNT_W'(1);
            if (rx_byte_i <= ASCII_ZERO) begin
              step_d = CNT_W'(1);
            end else if (len > (BYTE_W+1)'(MAX_STEPS)) begin
              step_d = CNT_W'(MAX_STEPS);
            end else begin
              step_d = CNT_W'(len);
            end
          end else begin
            we_o   = 1'b1;
            load_d = load_q + CNT_W'(1);
            if (load_q == step_q) begin
              load_d    = '0;
              play_d    = '0;
              running_d = 1'b1;
              ack       = 1'b1;
            end
          end
        end
        MODE_TICK: begin
          if (running_q) begin
            if (due) begin
              count_d = '0;
              fire    = 1'b1;
              play_d  = (play_inc >= step_q) ? '0 : IDX_W'(play_inc);
            end else begin
              count_d = count_q + TICK_W'(1);
            end
          end
        end
        MODE_SLOWER: begin
          if (period_q <= {1'b0, pmax_q}) begin
            period_d = dbl[PERIOD_W] ? '1 : dbl[PERIOD_W-1:0];
            count_d  = '0;
          end
        end
        MODE_FASTER: begin
          if (period_q >= {1'b0, pmin_q}) begin
            period_d = (half == '0) ? PERIOD_W'(1) : half;
            count_d  = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // the memory is read at the play index on every accepted beat
  assign re_o    = acc_i;
  assign raddr_o = play_q;

  assign item_o.fire    = fire;
  assign item_o.ack     = ack;
  assign item_o.playing = running_d;
  assign item_o.period  = period_d;

  assign rd_valid_o = rd_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q    <= TICKS_RST;
      pmax_q     <= PMAX_RST;
      pmin_q     <= PMIN_RST;
      step_q     <= CNT_W'(1);
      load_q     <= '0;
      play_q     <= '0;
      running_q  <= 1'b1;
      count_q    <= '0;
      period_q   <= DEFAULT_PERIOD;
      prod_q     <= PROD_RST;
      vld_q      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      ticks_q   <= ticks_d;
      pmax_q    <= pmax_d;
      pmin_q    <= pmin_d;
      step_q    <= step_d;
      load_q    <= load_d;
      play_q    <= play_d;
      running_q <= running_d;
      count_q   <= count_d;
      period_q  <= period_d;
      // reload product always tracks the next period and tick scale
      prod_q    <= period_d * ticks_d;
      if (we_o) begin
        vld_q[waddr_o] <= 1'b1;
      end
      if (re_o) begin
        rd_valid_q <= vld_q[raddr_o];
      end
    end
  end

endmodule

### sv/slp_out.sv
// output side of the player: one stage that waits for the memory read,
// the led state register and the result register; depends on slp_pkg and slp_ifs
module slp_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_i,
  input  slp_pkg::slp_item_t            item_i,
  input  logic [slp_pkg::LED_W-1:0]     rd_data_i,
  input  logic                          rd_valid_i,
  output logic                          in_ready_o,
  slp_res_if.source                     result_o
);
  import slp_pkg::*;

  slp_item_t        s1_q;
  logic             s1_valid_q, s1_valid_d;
  logic             s1_adv;
  logic [LED_W-1:0] led_q, led_next;
  logic             res_valid_q, res_valid_d;
  logic [LED_W-1:0] res_leds_q;
  logic             res_ack_q, res_play_q;
  logic [PERIOD_W-1:0] res_period_q;

  assign s1_adv     = s1_valid_q && (!res_valid_q || result_o.ready);
  assign in_ready_o = !s1_valid_q || s1_adv;

  // never written entries read as zero
  assign led_next = s1_q.fire ? (rd_valid_i ? rd_data_i : '0) : led_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (acc_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    res_valid_d = res_valid_q;
    if (s1_adv) begin
      res_valid_d = 1'b1;
    end else if (result_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      led_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
      if (s1_adv) begin
        led_q <= led_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_q <= item_i;
    end
    if (s1_adv) begin
      res_leds_q   <= led_next;
      res_ack_q    <= s1_q.ack;
      res_play_q   <= s1_q.playing;
      res_period_q <= s1_q.period;
    end
  end

  assign result_o.valid      = res_valid_q;
  assign result_o.leds       = res_leds_q;
  assign result_o.ack_valid  = res_ack_q;
  assign result_o.playing    = res_play_q;
  assign result_o.period_now = res_period_q;

endmodule

### sv/serial_loaded_led_pattern_player_top.sv
// Serial loaded LED pattern player. Every accepted item (serial byte, timer
// tick or speed button) gives exactly one result, via the wait stage and the
// result register. One item is taken per cycle, back to back, unless results
// stall; the pattern sits in a MAX_STEPS x 4 memory with a registered read,
// issued at the play index on acceptance and resolved in the following
// stage. Config writes are always ready and take effect for the next item.
// top level: depends on slp_pkg, the channel interfaces, slp_ram, slp_ctrl,
// slp_out and the assertion macro header
`include "serial_loaded_led_pattern_player_top_assert.svh"

module serial_loaded_led_pattern_player_top #(
  parameter int unsigned MAX_STEPS = slp_pkg::MAX_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  slp_item_if.sink    item_i,
  slp_res_if.source   result_o,
  slp_cfg_if.sink     cfg_i
);
  import slp_pkg::*;

  localparam int unsigned IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  logic             acc;
  logic             in_ready;
  logic             we, re, rd_valid;
  logic [IDX_W-1:0] waddr, raddr;
  logic [LED_W-1:0] wdata, rdata;
  slp_item_t        item;
  logic             res_slot_free;

  assign item_i.ready = in_ready;
  assign acc          = item_i.valid && in_ready;

  // result register empty or handing off this cycle
  assign res_slot_free = !result_o.valid || result_o.ready;

  slp_ctrl #(
    .MAX_STEPS (MAX_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .acc_i      (acc),
    .mode_i     (item_i.mode),
    .rx_byte_i  (item_i.rx_byte),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .re_o       (re),
    .raddr_o    (raddr),
    .rd_valid_o (rd_valid),
    .item_o     (item)
  );

  slp_ram #(
    .WIDTH (LED_W),
    .DEPTH (MAX_STEPS)
  ) u_pattern_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  slp_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .item_i     (item),
    .rd_data_i  (rdata),
    .rd_valid_i (rd_valid),
    .in_ready_o (in_ready),
    .result_o   (result_o)
  );

  // a completed load always resumes playback
  `SLP_ASSERT_NOW(a_ack_playing, result_o.valid && result_o.ack_valid, result_o.playing)
  // the period never drops to zero
  `SLP_ASSERT_NOW(a_period_nz, result_o.valid, result_o.period_now != '0)
  // with a beat in the middle stage, input ready follows the result slot
  `SLP_ASSERT_NEXT(a_ready_link, item_i.valid && item_i.ready, item_i.ready == res_slot_free)

endmodule

### test/led_player_monitor.sv
`timescale 1ns / 1ps
// follows the item, result and config channels of the led pattern player,
// predicts the status for every item beat and compares each result beat
// depends on slp_pkg and the channel interfaces in slp_ifs
module led_player_monitor #(
  parameter int unsigned MAX_STEPS  = slp_pkg::MAX_STEPS_DEF,
  parameter int unsigned REPORT_CAP = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  slp_item_if         item_i,
  slp_res_if          result_i,
  slp_cfg_if          cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import slp_pkg::*;

  localparam int unsigned STEP_W = $clog2(MAX_STEPS + 2);

  typedef struct packed {
    logic [LED_W-1:0]    leds;
    logic                ack;
    logic                playing;
    logic [PERIOD_W-1:0] period;
  } led_status_t;

  // configuration copy
  logic [CFG_W-1:0]   ticks_per_ms;
  logic [LIMIT_W-1:0] period_max;
  logic [LIMIT_W-1:0] period_min;

  // player state
  logic [LED_W-1:0]    pattern [MAX_STEPS];
  logic [STEP_W-1:0]   step_cnt;
  logic [STEP_W-1:0]   load_pos;
  logic [STEP_W-1:0]   play_pos;
  logic                running;
  logic [TICK_W-1:0]   tick_cnt;
  logic [PERIOD_W-1:0] period;
  logic [LED_W-1:0]    led_level;

  led_status_t awaited_status[$];
  int unsigned mismatches;

  function automatic led_status_t play_item(mode_e mode, logic [BYTE_W-1:0] rx);
    led_status_t        st;
    logic [TICK_W-1:0]  prod;
    logic [TICK_W-1:0]  reload;
    logic [PERIOD_W:0]  twice;
    logic [BYTE_W-1:0]  len;
    logic               ack;
    ack = 1'b0;
    case (mode)
      MODE_BYTE: begin
        if (load_pos == 0) begin
          // length byte: pause playback and clamp the step count
          running = 1'b0;
          len = rx - ASCII_ZERO;
          if (rx <= ASCII_ZERO) step_cnt = 1;
          else if (len > MAX_STEPS) step_cnt = STEP_W'(MAX_STEPS);
          else step_cnt = STEP_W'(len);
          load_pos = 1;
        end else begin
          pattern[load_pos - 1] = rx[LED_W-1:0];
          load_pos = load_pos + 1;
          if (load_pos > step_cnt) begin
            load_pos = 0;
            play_pos = 0;
            running  = 1'b1;
            ack      = 1'b1;
          end
        end
      end
      MODE_TICK: begin
        if (running) begin
          prod   = TICK_W'(period) * TICK_W'(ticks_per_ms);
          reload = (prod == 0) ? '0 : prod - 1;
          if (tick_cnt >= reload) begin
            tick_cnt  = '0;
            led_level = pattern[play_pos];
            play_pos  = play_pos + 1;
            if (play_pos >= step_cnt) play_pos = 0;
          end else begin
            tick_cnt = tick_cnt + 1;
          end
        end
      end
      MODE_SLOWER: begin
        if (period <= PERIOD_W'(period_max)) begin
          twice    = {period, 1'b0};
          period   = (twice > 17'h0FFFF) ? 16'hFFFF : twice[PERIOD_W-1:0];
          tick_cnt = '0;
        end
      end
      MODE_FASTER: begin
        if (period >= PERIOD_W'(period_min)) begin
          period   = ((period >> 1) == 0) ? 16'd1 : (period >> 1);
          tick_cnt = '0;
        end
      end
      default: ;
    endcase
    st.leds    = led_level;
    st.ack     = ack;
    st.playing = running;
    st.period  = period;
    return st;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    led_status_t got;
    led_status_t want;
    if (!rst_ni) begin
      ticks_per_ms = TICKS_RST;
      period_max   = PMAX_RST;
      period_min   = PMIN_RST;
      foreach (pattern[i]) pattern[i] = '0;
      step_cnt     = 1;
      load_pos     = 0;
      play_pos     = 0;
      running      = 1'b1;
      tick_cnt     = '0;
      period       = DEFAULT_PERIOD;
      led_level    = '0;
      awaited_status.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_reg_e'(cfg_i.index))
          REG_TICKS_PER_MS: ticks_per_ms = cfg_i.data;
          REG_PERIOD_MAX:   period_max   = cfg_i.data[LIMIT_W-1:0];
          REG_PERIOD_MIN:   period_min   = cfg_i.data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (result_i.valid && result_i.ready) begin
        got.leds    = result_i.leds;
        got.ack     = result_i.ack_valid;
        got.playing = result_i.playing;
        got.period  = result_i.period_now;
        if (awaited_status.size() == 0) begin
          if (mismatches < REPORT_CAP)
            $display("result beat with nothing awaited: leds %h ack %b playing %b period %0d",
                     got.leds, got.ack, got.playing, got.period);
          mismatches++;
        end else begin
          want = awaited_status.pop_front();
          if (got != want) begin
            if (mismatches < REPORT_CAP) begin
              $display("status mismatch: expected leds %h ack %b playing %b period %0d",
                       want.leds, want.ack, want.playing, want.period);
              $display("                 got      leds %h ack %b playing %b period %0d",
                       got.leds, got.ack, got.playing, got.period);
            end
            mismatches++;
          end
        end
      end
      if (item_i.valid && item_i.ready)
        awaited_status.push_back(play_item(mode_e'(item_i.mode), item_i.rx_byte));
      fail_count_o <= mismatches;
      pending_o    <= awaited_status.size();
    end
  end

endmodule

### test/tb_serial_loaded_led_pattern_player_top.sv
`timescale 1ns / 1ps
// top of the led pattern player bench: clock, reset, directed and random
// items, config phases, result backpressure and the verdict
// depends on slp_pkg, slp_ifs, the player rtl and led_player_monitor
module tb_serial_loaded_led_pattern_player_top;
  import slp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS  = 95;

  logic        clk;
  logic        rst_n;
  logic        tx_calm;
  int unsigned rx_stall;
  int unsigned rx_calm_left;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_cnt = 0;

  slp_item_if item_bus ();
  slp_res_if  result_bus ();
  slp_cfg_if  cfg_bus ();

  serial_loaded_led_pattern_player_top u_top (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (item_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  led_player_monitor u_monitor (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .item_i       (item_bus),
    .result_i     (result_bus),
    .cfg_i        (cfg_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_serial_loaded_led_pattern_player_top NOT OK");
      $finish;
    end
  end

  // result side: after each beat a random stall or none, with calm stretches
  always @(posedge clk or negedge rst_n) begin : result_side
    int unsigned draw;
    if (!rst_n) begin
      result_bus.ready <= 1'b0;
      rx_stall         <= 0;
      rx_calm_left     <= 0;
    end else if (result_bus.ready) begin
      if (result_bus.valid) begin
        draw = (rx_calm_left != 0) ? 0 : $urandom_range(0, 7);
        if (rx_calm_left != 0) rx_calm_left <= rx_calm_left - 1;
        else if ($urandom_range(0, 15) == 0) rx_calm_left <= $urandom_range(10, 40);
        if (draw != 0) begin
          result_bus.ready <= 1'b0;
          rx_stall         <= draw;
        end
      end
    end else begin
      if (rx_stall <= 1) result_bus.ready <= 1'b1;
      if (rx_stall != 0) rx_stall <= rx_stall - 1;
    end
  end

  function automatic logic [BYTE_W-1:0] any_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // leaves valid high so a back to back beat needs no second assignment
  task automatic send_item(mode_e mode, logic [BYTE_W-1:0] rx);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid   <= 1'b1;
    item_bus.mode    <= mode;
    item_bus.rx_byte <= rx;
    do @(posedge clk); while (!item_bus.ready);
  endtask

  // writes all three registers back to back, period limits with a random top bit
  task automatic configure(logic [CFG_W-1:0] ticks, logic [LIMIT_W-1:0] pmax,
                           logic [LIMIT_W-1:0] pmin);
    cfg_reg_e         idx  [3];
    logic [CFG_W-1:0] vals [3];
    idx[0]  = REG_TICKS_PER_MS;
    idx[1]  = REG_PERIOD_MAX;
    idx[2]  = REG_PERIOD_MIN;
    vals[0] = ticks;
    vals[1] = {1'($urandom_range(0, 1)), pmax};
    vals[2] = {1'($urandom_range(0, 1)), pmin};
    for (int i = 0; i < 3; i++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx[i];
      cfg_bus.data  <= vals[i];
      do @(posedge clk); while (!cfg_bus.ready);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_traffic(int unsigned n_items);
    int unsigned       sent;
    int unsigned       pick;
    int unsigned       fill;
    int unsigned       burst;
    logic [BYTE_W-1:0] len_byte;
    sent = 0;
    while (sent < n_items) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        if ($urandom_range(0, 9) == 0) len_byte = any_byte();
        else if ($urandom_range(0, 3) == 0) len_byte = BYTE_W'(ASCII_ZERO + $urandom_range(1, 16));
        else len_byte = BYTE_W'(ASCII_ZERO + $urandom_range(1, 4));
        if (len_byte <= ASCII_ZERO) fill = 1;
        else if (len_byte - ASCII_ZERO > MAX_STEPS_DEF) fill = MAX_STEPS_DEF;
        else fill = len_byte - ASCII_ZERO;
        // cut load short now and then, later beats finish it
        if ($urandom_range(0, 9) == 0) fill = $urandom_range(0, fill - 1);
        send_item(MODE_BYTE, len_byte);
        repeat (fill) begin
          if ($urandom_range(0, 5) == 0) send_item(mode_e'($urandom_range(1, 3)), any_byte());
          send_item(MODE_BYTE, any_byte());
        end
        sent += fill + 1;
      end else if (pick < 80) begin
        burst = $urandom_range(1, 16);
        repeat (burst) send_item(MODE_TICK, any_byte());
        sent += burst;
      end else begin
        send_item(($urandom_range(0, 4) < 3) ? MODE_FASTER : MODE_SLOWER, any_byte());
        sent++;
      end
    end
    item_bus.valid <= 1'b0;
  endtask

  initial begin
    tx_calm          = 1'b0;
    rst_n            <= 1'b0;
    item_bus.valid   <= 1'b0;
    item_bus.mode    <= MODE_TICK;
    item_bus.rx_byte <= '0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= REG_TICKS_PER_MS;
    cfg_bus.data     <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: buttons, paused ticks, length bytes at and below ascii zero
    send_item(MODE_TICK, 8'h00);
    send_item(MODE_SLOWER, 8'hFF);
    send_item(MODE_FASTER, 8'h00);
    send_item(MODE_BYTE, ASCII_ZERO);
    send_item(MODE_TICK, 8'hFF);
    send_item(MODE_FASTER, 8'h55);
    send_item(MODE_BYTE, 8'hFF);
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_BYTE, 8'hA5);
    item_bus.valid <= 1'b0;
    wait_drained();

    // zero tick rate fires every tick; halving clamps at one
    configure(16'd0, 15'd32767, 15'd1);
    send_item(MODE_BYTE, 8'h33);
    send_item(MODE_BYTE, 8'h1C);
    send_item(MODE_BYTE, 8'h2D);
    send_item(MODE_BYTE, 8'h3E);
    repeat (4) send_item(MODE_TICK, any_byte());
    repeat (8) send_item(MODE_FASTER, any_byte());
    item_bus.valid <= 1'b0;
    wait_drained();

    configure(16'd1, 15'd32767, 15'd1);
    random_traffic(PHASE_ITEMS);
    wait_drained();

    configure(16'd0, 15'd1, 15'd32767);
    random_traffic(PHASE_ITEMS);
    wait_drained();

    configure(16'd65535, 15'd32767, 15'd1);
    random_traffic(PHASE_ITEMS);
    wait_drained();

    configure(16'd2, 15'd16, 15'd2);
    random_traffic(PHASE_ITEMS);
    wait_drained();

    if (fail_count == 0)
      $display("tb_serial_loaded_led_pattern_player_top OK");
    else
      $display("tb_serial_loaded_led_pattern_player_top NOT OK");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/slp_pkg.sv
sv/slp_ifs.sv
sv/slp_ram.sv
sv/slp_ctrl.sv
sv/slp_out.sv
sv/serial_loaded_led_pattern_player_top.sv
test/led_player_monitor.sv
test/tb_serial_loaded_led_pattern_player_top.sv
